// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property shorthands for the least-squares fit core. Each macro
// expects signals named clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LLS_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LLS_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The expression must never be true.
`define LLS_ASSERT_NEVER(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// ----- rtl/core/lls_pkg.sv -----
// ----------------------------------------------------------------------------
// Least-squares fit package
// Payload types, command and status structures and shared constants.
// ----------------------------------------------------------------------------
package lls_pkg;

    localparam int DEF_MAX_POINTS = 256;
    localparam int COORD_W        = 24;
    localparam int FIT_W          = 48;
    localparam int RESID_W        = 64;
    localparam int USED_W         = 9;
    localparam int ACC_W          = 128;
    localparam int OP_W           = 64;
    localparam int DIV_CNT_W      = 7;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_value;
        logic signed [COORD_W-1:0] y_value;
        logic                      last_point;
    } lls_in_t;

    typedef struct packed {
        logic signed [FIT_W-1:0] slope;
        logic signed [FIT_W-1:0] intercept;
        logic [RESID_W-1:0]      residual_squares;
        logic                    degenerate;
        logic [USED_W-1:0]       points_used;
    } lls_out_t;

    // Operand pairs for the shared multiplier.
    typedef logic [2:0] mul_sel_t;
    localparam mul_sel_t MS_N_SXX   = 3'd0;
    localparam mul_sel_t MS_SX_SX   = 3'd1;
    localparam mul_sel_t MS_N_SXY   = 3'd2;
    localparam mul_sel_t MS_SX_SY   = 3'd3;
    localparam mul_sel_t MS_SXX_SY  = 3'd4;
    localparam mul_sel_t MS_SX_SXY  = 3'd5;
    localparam mul_sel_t MS_SLOPE_X = 3'd6;
    localparam mul_sel_t MS_RES_SQ  = 3'd7;

    typedef struct packed {
        logic     store;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     mul_sub;
        logic     mul_clr;
        logic     div_start;
        logic     div_icpt;
        logic     save_d;
        logic     save_num;
        logic     save_mum;
        logic     walk_init;
        logic     walk_read;
        logic     walk_load;
        logic     walk_next;
        logic     out_load;
        logic     out_degen;
    } lls_cmd_t;

    typedef struct packed {
        logic full;
        logic mul_done;
        logic div_done;
        logic acc_nonpos;
        logic walk_last;
    } lls_status_t;

endpackage

// ----- rtl/core/linear_least_squares_fit_core.sv -----
// ----------------------------------------------------------------------------
// Linear least-squares fit core
// Streams (x, y) points, fits y = slope*x + intercept and reports the
// residual sum of squares once per data set.
// ----------------------------------------------------------------------------
// Points transfer in at one per cycle; each is written to the point memory
// while the count and the sums of x, y, x*y and x*x are updated in the same
// cycle. The transfer marked last_point starts the fit, and no further point
// is taken until the result has been loaded into the output register. The
// fit runs on a single shift-add multiplier that retires one multiplier bit
// per cycle, and on a restoring divider for the quotients. The six products
// of the fit terms come first, with the denominator check after the first
// two, then the two divisions, then the residual walk, which for each stored
// point takes a memory read, a load, a product with the 24-bit x and a
// square of a residual of at most 59 bits. The output register is then
// loaded once it is free. When the denominator is zero the fit stops after
// the denominator check, and a degenerate result with zero values is given.
// A point that arrives when MAX_POINTS are held is dropped. The result
// waits in an output register while new points of the next set transfer in.
`include "assert_macros.svh"

module linear_least_squares_fit_core #(
    parameter int MAX_POINTS = lls_pkg::DEF_MAX_POINTS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lls_pkg::lls_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output lls_pkg::lls_out_t out_data
);
    import lls_pkg::*;

    // Command and status between the sequencer and the datapath.
    lls_cmd_t    cmd;
    lls_status_t st;

    // High when the transfer in this cycle carries the last point.
    logic        in_xfer_last;

    assign in_xfer_last = in_valid && in_ready && in_data.last_point;

    lls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (in_data.last_point),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (st),
        .cmd       (cmd)
    );

    lls_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (st),
        .out_data (out_data)
    );

    // A last point must close the input until the fit is loaded into the output register.
    `LLS_ASSERT_NXT(a_last_closes_input, in_xfer_last, !in_ready, "input open after last point")

    // A new result only appears after a fit, never while points are taken.
    `LLS_ASSERT_IMP(a_result_after_fit, $rose(out_valid), !$past(in_ready), "result without fit")

    // The multiplier and the divider are never finishing at the same time.
    `LLS_ASSERT_NEVER(a_units_exclusive, st.mul_done && st.div_done, "units overlap")

endmodule

// ----- rtl/core/lls_dp.sv -----
// ----------------------------------------------------------------------------
// Least-squares fit datapath
// Running sums, point memory, shift-add multiplier, restoring divider,
// residual accumulator and output register.
// ----------------------------------------------------------------------------
module lls_dp #(
    parameter int MAX_POINTS = lls_pkg::DEF_MAX_POINTS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lls_pkg::lls_in_t     in_data,
    input  lls_pkg::lls_cmd_t    cmd,
    output lls_pkg::lls_status_t status,
    output lls_pkg::lls_out_t    out_data
);
    import lls_pkg::*;

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int AW     = $clog2(MAX_POINTS);
    localparam int SUM_W  = COORD_W + CNT_W;
    localparam int PSUM_W = 2 * COORD_W + CNT_W;
    localparam logic [FIT_W-1:0] SAT_POS = {1'b0, {(FIT_W-1){1'b1}}};
    localparam logic [FIT_W-1:0] SAT_NEG = {1'b1, {(FIT_W-1){1'b0}}};

    // Running sums and count.
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [SUM_W-1:0]  sx_reg, sy_reg;
    logic signed [PSUM_W-1:0] sxy_reg, sxx_reg;
    logic signed [2*COORD_W-1:0] xy_prod, xx_prod;

    // Point memory and walk.
    logic [2*COORD_W-1:0] mem [MAX_POINTS];
    logic [2*COORD_W-1:0] rd_reg;
    logic [AW-1:0]        idx_reg;
    logic signed [COORD_W-1:0] rd_x, rd_y;

    // Fit terms.
    logic signed [ACC_W-1:0] acc_reg, d_reg, num_reg, mum_reg;
    logic signed [FIT_W-1:0] slope_reg, icpt_reg;

    // Multiplier.
    logic [ACC_W-1:0] mul_a_reg, mul_p_reg;
    logic [OP_W-1:0]  mul_b_reg;
    logic             mul_busy_reg, mul_done_reg;
    logic             mul_neg_reg, mul_sub_reg, mul_clr_reg, mul_sq_reg;
    logic signed [OP_W-1:0] op_a, op_b;
    logic [OP_W-1:0]  mag_a, mag_b;
    logic signed [ACC_W-1:0] rsh, rmag;
    logic             eneg;
    logic [ACC_W-1:0] acc_base, acc_term;
    logic [ACC_W:0]   racc_sum;

    // Residual accumulator.
    logic [ACC_W-1:0] racc_reg;
    logic             sat_reg;

    // Divider.
    logic [ACC_W-1:0] div_n_reg, div_r_reg, div_q_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic             div_busy_reg, div_fin_reg, div_neg_reg, div_icpt_reg;
    logic signed [ACC_W-1:0] div_src;
    logic [ACC_W-1:0] div_start_val, div_r2;
    logic             div_ge, div_big;
    logic [FIT_W-1:0] div_mag, div_res;

    // Output.
    lls_out_t         out_reg;
    logic [ACC_W:0]   rnd;
    logic             resid_ovf;
    logic [RESID_W-1:0] resid_val;
    logic [CNT_W+USED_W-1:0] used_ext;

    assign xy_prod = in_data.x_value * in_data.y_value;
    assign xx_prod = in_data.x_value * in_data.x_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxy_reg <= '0;
            sxx_reg <= '0;
        end
        else if (cmd.out_load)
        begin
            cnt_reg <= '0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxy_reg <= '0;
            sxx_reg <= '0;
        end
        else if (cmd.store)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            sx_reg  <= sx_reg + SUM_W'(in_data.x_value);
            sy_reg  <= sy_reg + SUM_W'(in_data.y_value);
            sxy_reg <= sxy_reg + PSUM_W'(xy_prod);
            sxx_reg <= sxx_reg + PSUM_W'(xx_prod);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            mem[cnt_reg[AW-1:0]] <= {in_data.x_value, in_data.y_value};
        end
        if (cmd.walk_read)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

    assign rd_x = rd_reg[2*COORD_W-1:COORD_W];
    assign rd_y = rd_reg[COORD_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.walk_init)
        begin
            idx_reg <= '0;
        end
        else if (cmd.walk_next)
        begin
            idx_reg <= idx_reg + AW'(1);
        end
    end

    // Multiplier operand selection.
    always_comb
    begin
        case (cmd.mul_sel)
            MS_N_SXX:   begin op_a = OP_W'(sxx_reg);   op_b = OP_W'(cnt_reg); end
            MS_SX_SX:   begin op_a = OP_W'(sx_reg);    op_b = OP_W'(sx_reg);  end
            MS_N_SXY:   begin op_a = OP_W'(sxy_reg);   op_b = OP_W'(cnt_reg); end
            MS_SX_SY:   begin op_a = OP_W'(sx_reg);    op_b = OP_W'(sy_reg);  end
            MS_SXX_SY:  begin op_a = OP_W'(sxx_reg);   op_b = OP_W'(sy_reg);  end
            MS_SX_SXY:  begin op_a = OP_W'(sxy_reg);   op_b = OP_W'(sx_reg);  end
            MS_SLOPE_X: begin op_a = OP_W'(slope_reg); op_b = OP_W'(rd_x);    end
            default:    begin op_a = OP_W'(sxx_reg);   op_b = OP_W'(cnt_reg); end
        endcase
    end

    // The residual is rounded in the accumulator before it is squared.
    assign rsh  = acc_reg >>> 12;
    assign rmag = rsh[ACC_W-1] ? (~rsh + ACC_W'(1)) : rsh;

    always_comb
    begin
        if (cmd.mul_sel == MS_RES_SQ)
        begin
            mag_a = rmag[OP_W-1:0];
            mag_b = rmag[OP_W-1:0];
        end
        else
        begin
            mag_a = op_a[OP_W-1] ? (~op_a + OP_W'(1)) : op_a;
            mag_b = op_b[OP_W-1] ? (~op_b + OP_W'(1)) : op_b;
        end
    end

    assign eneg     = mul_neg_reg ^ mul_sub_reg;
    assign acc_base = mul_clr_reg ? '0 : acc_reg;
    assign acc_term = eneg ? ~mul_p_reg : mul_p_reg;
    assign racc_sum = {1'b0, racc_reg} + {1'b0, mul_p_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_busy_reg <= 1'b0;
            mul_done_reg <= 1'b0;
            sat_reg      <= 1'b0;
        end
        else
        begin
            mul_done_reg <= 1'b0;
            if (cmd.walk_init)
            begin
                sat_reg <= 1'b0;
            end
            if (cmd.mul_start)
            begin
                mul_busy_reg <= 1'b1;
            end
            else if (mul_busy_reg && (mul_b_reg == '0))
            begin
                mul_busy_reg <= 1'b0;
                mul_done_reg <= 1'b1;
                if (mul_sq_reg)
                begin
                    sat_reg <= sat_reg | racc_sum[ACC_W];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            mul_a_reg   <= ACC_W'(mag_a);
            mul_b_reg   <= mag_b;
            mul_p_reg   <= '0;
            mul_neg_reg <= (cmd.mul_sel != MS_RES_SQ) && (op_a[OP_W-1] ^ op_b[OP_W-1]);
            mul_sub_reg <= cmd.mul_sub;
            mul_clr_reg <= cmd.mul_clr;
            mul_sq_reg  <= (cmd.mul_sel == MS_RES_SQ);
        end
        else if (mul_busy_reg)
        begin
            if (mul_b_reg != '0)
            begin
                if (mul_b_reg[0])
                begin
                    mul_p_reg <= mul_p_reg + mul_a_reg;
                end
                mul_a_reg <= mul_a_reg << 1;
                mul_b_reg <= mul_b_reg >> 1;
            end
        end

        if (cmd.walk_load)
        begin
            acc_reg <= (ACC_W'(rd_y) <<< 24) - (ACC_W'(icpt_reg) <<< 12)
                       + ACC_W'(2048);
        end
        else if (mul_busy_reg && (mul_b_reg == '0) && !mul_sq_reg)
        begin
            acc_reg <= acc_base + acc_term + ACC_W'(eneg);
        end

        if (cmd.walk_init)
        begin
            racc_reg <= '0;
        end
        else if (mul_busy_reg && (mul_b_reg == '0) && mul_sq_reg)
        begin
            racc_reg <= racc_sum[ACC_W-1:0];
        end

        if (cmd.save_d)
        begin
            d_reg <= acc_reg;
        end
        if (cmd.save_num)
        begin
            num_reg <= acc_reg;
        end
        if (cmd.save_mum)
        begin
            mum_reg <= acc_reg;
        end
    end

    // Divider: rounded magnitude over the positive denominator.
    assign div_src       = cmd.div_icpt ? (mum_reg <<< 12) : (num_reg <<< 24);
    assign div_start_val = (div_src[ACC_W-1] ? ~div_src : div_src) + (d_reg >> 1)
                           + ACC_W'(div_src[ACC_W-1]);
    assign div_r2        = {div_r_reg[ACC_W-2:0], div_n_reg[ACC_W-1]};
    assign div_ge        = div_r2 >= d_reg;

    always_comb
    begin
        if (div_neg_reg)
        begin
            div_big = (|div_q_reg[ACC_W-1:FIT_W])
                      || (div_q_reg[FIT_W-1] && (|div_q_reg[FIT_W-2:0]));
            div_mag = div_big ? SAT_NEG : div_q_reg[FIT_W-1:0];
            div_res = ~div_mag + FIT_W'(1);
        end
        else
        begin
            div_big = |div_q_reg[ACC_W-1:FIT_W-1];
            div_mag = div_big ? SAT_POS : div_q_reg[FIT_W-1:0];
            div_res = div_mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_fin_reg  <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            div_fin_reg <= 1'b0;
            if (cmd.div_start)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= DIV_CNT_W'(ACC_W - 1);
            end
            else if (div_busy_reg)
            begin
                if (div_cnt_reg == '0)
                begin
                    div_busy_reg <= 1'b0;
                    div_fin_reg  <= 1'b1;
                end
                else
                begin
                    div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            div_n_reg    <= div_start_val;
            div_r_reg    <= '0;
            div_q_reg    <= '0;
            div_neg_reg  <= div_src[ACC_W-1];
            div_icpt_reg <= cmd.div_icpt;
        end
        else if (div_busy_reg)
        begin
            div_r_reg <= div_ge ? (div_r2 - d_reg) : div_r2;
            div_q_reg <= {div_q_reg[ACC_W-2:0], div_ge};
            div_n_reg <= div_n_reg << 1;
        end

        if (div_fin_reg)
        begin
            if (div_icpt_reg)
            begin
                icpt_reg <= div_res;
            end
            else
            begin
                slope_reg <= div_res;
            end
        end
    end

    // Final rounding of the residual sum from Q.24 to an integer.
    assign rnd       = {1'b0, racc_reg} + (ACC_W+1)'(1 << 23);
    assign resid_ovf = sat_reg || rnd[ACC_W] || (|rnd[ACC_W-1:RESID_W+24]);
    assign resid_val = resid_ovf ? '1 : rnd[RESID_W+23:24];
    assign used_ext  = {{USED_W{1'b0}}, cnt_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.slope            <= cmd.out_degen ? '0 : slope_reg;
            out_reg.intercept        <= cmd.out_degen ? '0 : icpt_reg;
            out_reg.residual_squares <= cmd.out_degen ? '0 : resid_val;
            out_reg.degenerate       <= cmd.out_degen;
            out_reg.points_used      <= used_ext[USED_W-1:0];
        end
    end

    assign out_data          = out_reg;
    assign status.full       = (cnt_reg == CNT_W'(MAX_POINTS));
    assign status.mul_done   = mul_done_reg;
    assign status.div_done   = div_fin_reg;
    assign status.acc_nonpos = acc_reg[ACC_W-1] || (acc_reg == '0);
    assign status.walk_last  = (CNT_W'(idx_reg) == (cnt_reg - CNT_W'(1)));

endmodule

// ----- rtl/core/lls_ctrl.sv -----
// ----------------------------------------------------------------------------
// Least-squares fit controller
// Sequences accumulation, the fit terms, the two divisions and the
// residual walk, and owns the output handshake.
// ----------------------------------------------------------------------------
module lls_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_last,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  lls_pkg::lls_status_t status,
    output lls_pkg::lls_cmd_t    cmd
);
    import lls_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_D_A    = 5'd1;
    localparam logic [4:0] S_D_AW   = 5'd2;
    localparam logic [4:0] S_D_B    = 5'd3;
    localparam logic [4:0] S_D_BW   = 5'd4;
    localparam logic [4:0] S_D_CHK  = 5'd5;
    localparam logic [4:0] S_N_A    = 5'd6;
    localparam logic [4:0] S_N_AW   = 5'd7;
    localparam logic [4:0] S_N_B    = 5'd8;
    localparam logic [4:0] S_N_BW   = 5'd9;
    localparam logic [4:0] S_M_A    = 5'd10;
    localparam logic [4:0] S_M_AW   = 5'd11;
    localparam logic [4:0] S_M_B    = 5'd12;
    localparam logic [4:0] S_M_BW   = 5'd13;
    localparam logic [4:0] S_DV_S   = 5'd14;
    localparam logic [4:0] S_DV_SW  = 5'd15;
    localparam logic [4:0] S_DV_I   = 5'd16;
    localparam logic [4:0] S_DV_IW  = 5'd17;
    localparam logic [4:0] S_W_RD   = 5'd18;
    localparam logic [4:0] S_W_LD   = 5'd19;
    localparam logic [4:0] S_W_MX   = 5'd20;
    localparam logic [4:0] S_W_MXW  = 5'd21;
    localparam logic [4:0] S_W_SQ   = 5'd22;
    localparam logic [4:0] S_W_SQW  = 5'd23;
    localparam logic [4:0] S_OUT    = 5'd24;

    logic [4:0] state_reg, state_next;
    logic       degen_reg, degen_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        degen_next     = degen_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.store = !status.full;
                    if (in_last)
                    begin
                        state_next = S_D_A;
                    end
                end
            end
            S_D_A:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_N_SXX;
                cmd.mul_clr   = 1'b1;
                state_next    = S_D_AW;
            end
            S_D_AW:  if (status.mul_done) state_next = S_D_B;
            S_D_B:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_SX_SX;
                cmd.mul_sub   = 1'b1;
                state_next    = S_D_BW;
            end
            S_D_BW:  if (status.mul_done) state_next = S_D_CHK;
            S_D_CHK:
            begin
                cmd.save_d = 1'b1;
                degen_next = status.acc_nonpos;
                state_next = status.acc_nonpos ? S_OUT : S_N_A;
            end
            S_N_A:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_N_SXY;
                cmd.mul_clr   = 1'b1;
                state_next    = S_N_AW;
            end
            S_N_AW:  if (status.mul_done) state_next = S_N_B;
            S_N_B:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_SX_SY;
                cmd.mul_sub   = 1'b1;
                state_next    = S_N_BW;
            end
            S_N_BW:  if (status.mul_done) state_next = S_M_A;
            S_M_A:
            begin
                cmd.save_num  = 1'b1;
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_SXX_SY;
                cmd.mul_clr   = 1'b1;
                state_next    = S_M_AW;
            end
            S_M_AW:  if (status.mul_done) state_next = S_M_B;
            S_M_B:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_SX_SXY;
                cmd.mul_sub   = 1'b1;
                state_next    = S_M_BW;
            end
            S_M_BW:  if (status.mul_done) state_next = S_DV_S;
            S_DV_S:
            begin
                cmd.save_mum  = 1'b1;
                cmd.div_start = 1'b1;
                cmd.walk_init = 1'b1;
                state_next    = S_DV_SW;
            end
            S_DV_SW: if (status.div_done) state_next = S_DV_I;
            S_DV_I:
            begin
                cmd.div_start = 1'b1;
                cmd.div_icpt  = 1'b1;
                state_next    = S_DV_IW;
            end
            S_DV_IW: if (status.div_done) state_next = S_W_RD;
            S_W_RD:
            begin
                cmd.walk_read = 1'b1;
                state_next    = S_W_LD;
            end
            S_W_LD:
            begin
                cmd.walk_load = 1'b1;
                state_next    = S_W_MX;
            end
            S_W_MX:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_SLOPE_X;
                cmd.mul_sub   = 1'b1;
                state_next    = S_W_MXW;
            end
            S_W_MXW: if (status.mul_done) state_next = S_W_SQ;
            S_W_SQ:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_RES_SQ;
                state_next    = S_W_SQW;
            end
            S_W_SQW:
            begin
                if (status.mul_done)
                begin
                    if (status.walk_last)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cmd.walk_next = 1'b1;
                        state_next    = S_W_RD;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_degen  = degen_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            degen_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            degen_reg     <= degen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- verif/linear_least_squares_fit_core_test.sv -----
// ----------------------------------------------------------------------------
// Least-squares fit core testbench
// Streams data sets of (x, y) points through the core and compares every fit
// result against a cycle-free model of the fit kept inside this bench. A
// short table of directed sets comes first, then random sets of mostly small
// size, a few over-full sets, and sets with all x equal.
// ----------------------------------------------------------------------------
module linear_least_squares_fit_core_test;

    import lls_pkg::*;

    typedef logic signed [127:0] s128_t;
    typedef logic [127:0]        u128_t;

    localparam int NPTS     = DEF_MAX_POINTS;
    localparam int WDOG_MAX = 400000;

    typedef struct {
        int       x;
        int       y;
        bit       last;
        bit       typed;
        lls_out_t fit;
    } row_t;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    lls_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    lls_out_t out_data;

    // Bench copy of the accumulators and the point memory.
    longint sum_x, sum_y, sum_xy, sum_xx;
    int     held;
    longint pts_x[NPTS];
    longint pts_y[NPTS];

    lls_out_t fit_queue[$];
    int       mismatches;
    int       fits_seen;
    int       points_sent;
    int       idle_cycles;

    linear_least_squares_fit_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Round num/den to nearest, ties away from zero, saturate to 48 bits.
    function automatic longint round_div_sat(s128_t num, s128_t den);
        bit     neg;
        u128_t  mag;
        u128_t  quo;
        longint lim;
        begin
            neg = num[127];
            mag = neg ? u128_t'(-num) : u128_t'(num);
            quo = (mag + (u128_t'(den) >> 1)) / u128_t'(den);
            lim = neg ? (longint'(1) <<< 47) : ((longint'(1) <<< 47) - 1);
            if (quo > u128_t'(lim))
                quo = u128_t'(lim);
            return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
        end
    endfunction

    // Accumulate one point; on the last point of a set return the fit.
    function automatic bit fit_point(int x, int y, bit last, output lls_out_t fit);
        s128_t   den, num, mum, r;
        u128_t   mag, sq;
        logic [128:0] acc, nxt, rnd;
        bit      sat;
        longint  slope, icpt;
        begin
            fit = '0;
            if (held < NPTS)
            begin
                pts_x[held] = x;
                pts_y[held] = y;
                sum_x  += x;
                sum_y  += y;
                sum_xy += longint'(x) * longint'(y);
                sum_xx += longint'(x) * longint'(x);
                held++;
            end
            if (!last)
                return 1'b0;
            den = s128_t'(held) * s128_t'(sum_xx) - s128_t'(sum_x) * s128_t'(sum_x);
            if (den <= 0)
            begin
                fit.degenerate = 1'b1;
            end
            else
            begin
                num = s128_t'(held) * s128_t'(sum_xy) - s128_t'(sum_x) * s128_t'(sum_y);
                mum = s128_t'(sum_xx) * s128_t'(sum_y) - s128_t'(sum_x) * s128_t'(sum_xy);
                slope = round_div_sat(num <<< 24, den);
                icpt  = round_div_sat(mum <<< 12, den);
                acc = '0;
                sat = 1'b0;
                for (int i = 0; i < held; i++)
                begin
                    r = (s128_t'(pts_y[i]) <<< 24) - s128_t'(slope) * s128_t'(pts_x[i])
                        - (s128_t'(icpt) <<< 12);
                    r = (r + 2048) >>> 12;
                    if (r < 0)
                        r = -r;
                    mag = u128_t'(r[63:0]);
                    sq  = mag * mag;
                    nxt = acc + {1'b0, sq};
                    if (nxt[128])
                        sat = 1'b1;
                    acc = {1'b0, nxt[127:0]};
                end
                rnd = acc + (129'd1 << 23);
                if (sat || rnd[128] || rnd[127:88] != '0)
                    fit.residual_squares = '1;
                else
                    fit.residual_squares = rnd[87:24];
                fit.slope     = slope[FIT_W-1:0];
                fit.intercept = icpt[FIT_W-1:0];
            end
            fit.points_used = held[USED_W-1:0];
            sum_x  = 0;
            sum_y  = 0;
            sum_xy = 0;
            sum_xx = 0;
            held   = 0;
            return 1'b1;
        end
    endfunction

    // Mostly back-to-back, sometimes a short pause, rarely a long one.
    function automatic int pick_gap();
        int r;
        begin
            r = $urandom_range(99);
            if (r < 60)
                return 0;
            else if (r < 92)
                return $urandom_range(3, 1);
            else
                return $urandom_range(80, 10);
        end
    endfunction

    function automatic int pick_coord();
        int r;
        begin
            r = $urandom_range(99);
            if (r < 40)
                return $signed($urandom_range(65535)) - 32768;
            else if (r < 50)
                return ($urandom_range(1)) ? 8388607 : -8388608;
            else
                return int'($urandom_range(16777215)) - 8388608;
        end
    endfunction

    // Present one point and hold it until the core takes it.
    task automatic send_point(int x, int y, bit last, bit typed, lls_out_t typed_fit);
        lls_out_t fit;
        int       gap;
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid = 1'b1;
            in_data.x_value    = x[COORD_W-1:0];
            in_data.y_value    = y[COORD_W-1:0];
            in_data.last_point = last;
            do
                @(posedge clk);
            while (!in_ready);
            points_sent++;
            if (fit_point(x, y, last, fit))
                fit_queue.insert(fit_queue.size(), typed ? typed_fit : fit);
            @(negedge clk);
        end
    endtask

    // Result side: random stalls on out_ready.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(99) < 70)
                out_ready = 1'b1;
            else
            begin
                out_ready = 1'b0;
                repeat (pick_gap()) @(negedge clk);
            end
        end
    end

    // Compare each result transfer with the oldest expected fit.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (fit_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected fit result %p", out_data);
            end
            else
            begin
                lls_out_t want;
                want = fit_queue.pop_front();
                fits_seen++;
                if (out_data !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("fit %0d mismatch: expected %p, got %p",
                                 fits_seen, want, out_data);
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_MAX)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        row_t     rows[$];
        row_t     rw;
        lls_out_t blank;
        int       set_len;
        int       sets;
        int       same_x;
        int       hold_off;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        mismatches  = 0;
        fits_seen   = 0;
        points_sent = 0;
        idle_cycles = 0;
        sum_x = 0; sum_y = 0; sum_xy = 0; sum_xx = 0; held = 0;
        blank = '0;

        // Single points are degenerate; so is a set with all x equal.
        rw = '{8388607, 8388607, 1, 1, blank};
        rw.fit.degenerate = 1'b1; rw.fit.points_used = 9'd1;
        rows.insert(rows.size(), rw);
        rw = '{-8388608, -8388608, 1, 1, blank};
        rw.fit.degenerate = 1'b1; rw.fit.points_used = 9'd1;
        rows.insert(rows.size(), rw);
        rows.insert(rows.size(), '{-8388608, 5, 0, 0, blank});
        rw = '{-8388608, 8388607, 1, 1, blank};
        rw.fit.degenerate = 1'b1; rw.fit.points_used = 9'd2;
        rows.insert(rows.size(), rw);
        // y = x through the origin: slope one, no residual.
        rows.insert(rows.size(), '{0, 0, 0, 0, blank});
        rw = '{4096, 4096, 1, 1, blank};
        rw.fit.slope = 48'sd16777216; rw.fit.points_used = 9'd2;
        rows.insert(rows.size(), rw);
        // Extreme x span with extreme y: steep and saturating cases.
        rows.insert(rows.size(), '{-8388608, 8388607, 0, 0, blank});
        rows.insert(rows.size(), '{8388607, -8388608, 1, 0, blank});
        rows.insert(rows.size(), '{0, -8388608, 0, 0, blank});
        rows.insert(rows.size(), '{1, 8388607, 1, 0, blank});
        rows.insert(rows.size(), '{-1, 8388607, 0, 0, blank});
        rows.insert(rows.size(), '{0, -8388608, 0, 0, blank});
        rows.insert(rows.size(), '{1, 8388607, 1, 0, blank});
        // Noisy small sets.
        rows.insert(rows.size(), '{100, 7, 0, 0, blank});
        rows.insert(rows.size(), '{-300, 900, 0, 0, blank});
        rows.insert(rows.size(), '{8000, -2, 0, 0, blank});
        rows.insert(rows.size(), '{12345, 54321, 1, 0, blank});
        rows.insert(rows.size(), '{8388607, 8388607, 0, 0, blank});
        rows.insert(rows.size(), '{-8388608, -8388608, 0, 0, blank});
        rows.insert(rows.size(), '{3, -8388608, 1, 0, blank});

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
            send_point(rows[i].x, rows[i].y, rows[i].last, rows[i].typed, rows[i].fit);

        // Random sets; a few overfill the point memory to exercise dropping.
        sets = 0;
        while (points_sent < 1200)
        begin
            if (sets == 20 || sets == 90 || sets == 160)
                set_len = NPTS + $urandom_range(6, 1);
            else if ($urandom_range(99) < 5)
                set_len = 1;
            else
                set_len = $urandom_range(8, 2);
            same_x = ($urandom_range(99) < 8) ? pick_coord() : 32'h7FFFFFFF;
            for (int k = 0; k < set_len; k++)
                send_point((same_x != 32'h7FFFFFFF) ? same_x : pick_coord(), pick_coord(),
                           k == set_len - 1, 1'b0, blank);
            sets++;
        end
        in_valid = 1'b0;

        while (fit_queue.size() != 0)
            @(posedge clk);
        hold_off = 0;
        while (hold_off < 2000)
        begin
            @(posedge clk);
            hold_off++;
        end

        $display("Sent %0d points in %0d random sets plus directed sets; %0d fits checked.",
                 points_sent, sets, fits_seen);
        $display("Covered degenerate sets, extreme coordinates and overfilled point memory.");
        if (mismatches == 0 && fit_queue.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- linear_least_squares_fit_core.f -----
+incdir+rtl/core
rtl/core/lls_pkg.sv
rtl/core/lls_dp.sv
rtl/core/lls_ctrl.sv
rtl/core/linear_least_squares_fit_core.sv
verif/linear_least_squares_fit_core_test.sv
